// ----- rtl/core/ripemd160_hash_core_macros.svh -----
// Assertion macros shared by the RIPEMD-160 core checker
`ifndef RIPEMD160_HASH_CORE_MACROS_SVH
`define RIPEMD160_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RMD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RMD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rmd160_pkg.sv -----
// Types, constants, round tables and helper functions for the RIPEMD-160 core
package rmd160_pkg;

  // Input beat kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_e;

  // Which of the two parallel lines a step unit serves
  typedef enum logic {
    LINE_LEFT,
    LINE_RIGHT
  } line_e;

  // Boolean functions of the five round groups
  typedef enum logic [2:0] {
    FN_XOR,
    FN_MUX,
    FN_ORN,
    FN_MUXZ,
    FN_XORN
  } func_e;

  // Working registers of one line
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } line_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned ChainWords = 5;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_IDX   = 3'd4;
  localparam logic [5:0] POS_LEN    = 6'd55;
  localparam logic [5:0] POS_LAST   = 6'd63;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [3:0] ROT_C      = 4'd10;

  localparam logic [0:4][31:0] CHAIN_INIT = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};

  localparam logic [0:4][31:0] K_LEFT = {
    32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};

  localparam logic [0:4][31:0] K_RIGHT = {
    32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000};

  // Message word selection, one nibble per round, round 0 first
  localparam logic [0:79][3:0] SEL_LEFT = {
    64'h0123456789abcdef, 64'h74d1a6f3c0952eb8, 64'h3ae49f812706db5c,
    64'h19ba08c4d37fe562, 64'h40597c2ae138b6fd};

  localparam logic [0:79][3:0] SEL_RIGHT = {
    64'h5e7092b4d6f81a3c, 64'h6b370d5aef8c4912, 64'hf5137e69b8c2a04d,
    64'h86413bf05c2d97ae, 64'hcfa4158762de039b};

  // Left rotate amounts, one nibble per round
  localparam logic [0:79][3:0] ROT_LEFT = {
    64'hbefc5879bdef6798, 64'h768db97f7cf9b7dc, 64'hbd67e9dfe8d65c75,
    64'hbcefef989e56865c, 64'h9f5b68dc5cdeb856};

  localparam logic [0:79][3:0] ROT_RIGHT = {
    64'h899bdff5778beec6, 64'h9df7c89b77c76fdb, 64'h97fb866ecd5edd75,
    64'hf58bee6e69c9c5f8, 64'h85c9c5e68d65fdbb};

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [3:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] boolf(input func_e sel, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
    logic [31:0] res;
    unique case (sel)
      FN_XOR:  res = x ^ y ^ z;
      FN_MUX:  res = (x & y) | (~x & z);
      FN_ORN:  res = (x | ~y) ^ z;
      FN_MUXZ: res = (x & z) | (y & ~z);
      default: res = x ^ (y | ~z);
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/rmd160_ram.sv -----
// Generic RAM: one write port, two registered read ports
module rmd160_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- rtl/core/rmd160_step.sv -----
// One RIPEMD-160 round step for either line, split into two halves
module rmd160_step (
  input  rmd160_pkg::line_e side_i,
  input  logic [6:0]        round_i,
  input  rmd160_pkg::line_t st_i,
  input  logic [31:0]       sum_i,
  input  logic [31:0]       word_i,
  output logic [3:0]        addr_o,
  output logic [31:0]       sum_o,
  output rmd160_pkg::line_t st_o
);
  import rmd160_pkg::*;

  logic [2:0]  grp;
  func_e       fsel;
  logic [31:0] kconst;
  logic [3:0]  rot;
  logic [31:0] rsum;

  assign grp = round_i[6:4];

  // Per-line table lookups; the right line runs the functions in reverse
  always_comb begin
    if (side_i == LINE_RIGHT) begin
      fsel   = func_e'(3'(FN_XORN - grp));
      kconst = K_RIGHT[grp];
      rot    = ROT_RIGHT[round_i];
      addr_o = SEL_RIGHT[round_i];
    end else begin
      fsel   = func_e'(grp);
      kconst = K_LEFT[grp];
      rot    = ROT_LEFT[round_i];
      addr_o = SEL_LEFT[round_i];
    end
  end

  // First half: a + f(b,c,d) + K, before the message word is read
  assign sum_o = st_i.a + boolf(fsel, st_i.b, st_i.c, st_i.d) + kconst;

  // Second half: add word, rotate, add e and shift the registers along
  assign rsum = rotl32(sum_i + word_i, rot);

  always_comb begin
    st_o.a = st_i.e;
    st_o.b = rsum + st_i.e;
    st_o.c = st_i.b;
    st_o.d = rotl32(st_i.c, ROT_C);
    st_o.e = st_i.d;
  end

endmodule

// ----- rtl/core/ripemd160_hash_core.sv -----
// RIPEMD-160 streaming hash core: top level and sequencer
//
// Message bytes enter one beat at a time (kind = byte) and are packed little-endian
// into a 16-word block RAM; byte beats are taken without a stall, except the one that
// completes a 64-byte block, after which the core stalls while it compresses:
// 80 rounds in two halves each (the first forms a + f + K while the block RAM read
// is in flight, the second adds the word, rotates and adds e), one shared step
// unit per line, then the final combine. An end beat pads byte by byte with one
// or two compressions in between, then presents the five digest words on the
// output channel, word 0 first, last_word set on the fifth. After the last word
// is taken the core is back at the initial chaining values with a zero count and
// accepts the next message.
module ripemd160_hash_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rmd160_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rmd160_pkg::out_t  out_data_o
);
  import rmd160_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] chain_q [ChainWords];
  logic [31:0] chain_d [ChainWords];
  logic [60:0] cnt_q, cnt_d;
  logic [6:0]  round_q, round_d;
  logic        phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic        first_q, first_d;
  logic        inlen_q, inlen_d;
  logic        done_q, done_d;
  logic        pad_q, pad_d;

  line_t       lw_q, lw_d, rw_q, rw_d;
  logic [31:0] lsum_q, lsum_d, rsum_q, rsum_d;
  logic [23:0] word_q, word_d;
  logic [63:0] len_q, len_d;

  logic        abs_en;
  logic [7:0]  abs_byte;
  logic [5:0]  pos;
  logic        ram_we;
  logic [3:0]  laddr, raddr;
  logic [31:0] lword, rword;
  logic [31:0] lsum_n, rsum_n;
  line_t       lnext, rnext;

  assign pos    = cnt_q[5:0];
  assign ram_we = abs_en && (pos[1:0] == 2'b11);

  // Message block store
  rmd160_ram #(
    .Width (32),
    .Depth (BlockWords)
  ) u_block_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (pos[5:2]),
    .wdata_i   ({abs_byte, word_q}),
    .raddr_a_i (laddr),
    .raddr_b_i (raddr),
    .rdata_a_o (lword),
    .rdata_b_o (rword)
  );

  // Step units, one per line
  rmd160_step u_step_left (
    .side_i  (LINE_LEFT),
    .round_i (round_q),
    .st_i    (lw_q),
    .sum_i   (lsum_q),
    .word_i  (lword),
    .addr_o  (laddr),
    .sum_o   (lsum_n),
    .st_o    (lnext)
  );

  rmd160_step u_step_right (
    .side_i  (LINE_RIGHT),
    .round_i (round_q),
    .st_i    (rw_q),
    .sum_i   (rsum_q),
    .word_i  (rword),
    .addr_o  (raddr),
    .sum_o   (rsum_n),
    .st_o    (rnext)
  );

  // Output beat straight from the chaining registers
  assign out_data_o.digest_word = chain_q[idx_q];
  assign out_data_o.last_word   = (idx_q == LAST_IDX);

  // Next state and control
  always_comb begin
    state_d  = state_q;
    chain_d  = chain_q;
    cnt_d    = cnt_q;
    round_d  = round_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    lcnt_d   = lcnt_q;
    first_d  = first_q;
    inlen_d  = inlen_q;
    done_d   = done_q;
    pad_d    = pad_q;
    lw_d     = lw_q;
    rw_d     = rw_q;
    lsum_d   = lsum_q;
    rsum_d   = rsum_q;
    word_d   = word_q;
    len_d    = len_q;
    abs_en   = 1'b0;
    abs_byte = in_data_i.data_byte;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_END) begin
            len_d   = {cnt_q, 3'b000};
            first_d = 1'b1;
            inlen_d = 1'b0;
            done_d  = 1'b0;
            pad_d   = 1'b1;
            lcnt_d  = '0;
            state_d = ST_PAD;
          end else begin
            abs_en = 1'b1;
          end
        end
      end

      ST_PAD: begin
        abs_en  = 1'b1;
        first_d = 1'b0;
        if (first_q) begin
          abs_byte = PAD_MARK;
        end else if (inlen_q) begin
          abs_byte = len_q[7:0];
        end else begin
          abs_byte = '0;
        end
        // length bytes follow once byte 55 is filled
        if (inlen_q) begin
          len_d  = {8'h00, len_q[63:8]};
          lcnt_d = lcnt_q + 3'd1;
          if (lcnt_q == 3'd7) begin
            done_d = 1'b1;
          end
        end else if (pos == POS_LEN) begin
          inlen_d = 1'b1;
        end
      end

      ST_ROUND: begin
        if (!phase_q) begin
          lsum_d  = lsum_n;
          rsum_d  = rsum_n;
          phase_d = 1'b1;
        end else begin
          lw_d    = lnext;
          rw_d    = rnext;
          phase_d = 1'b0;
          round_d = round_q + 7'd1;
          if (round_q == LAST_ROUND) begin
            round_d = '0;
            state_d = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        chain_d[0] = chain_q[1] + lw_q.c + rw_q.d;
        chain_d[1] = chain_q[2] + lw_q.d + rw_q.e;
        chain_d[2] = chain_q[3] + lw_q.e + rw_q.a;
        chain_d[3] = chain_q[4] + lw_q.a + rw_q.b;
        chain_d[4] = chain_q[0] + lw_q.b + rw_q.c;
        if (done_q) begin
          state_d = ST_EMIT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_IDX) begin
            for (int i = 0; i < ChainWords; i++) begin
              chain_d[i] = CHAIN_INIT[i];
            end
            cnt_d   = '0;
            idx_d   = '0;
            pad_d   = 1'b0;
            done_d  = 1'b0;
            inlen_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Byte absorb: shift into the word buffer, compress on the last byte
    if (abs_en) begin
      word_d = {abs_byte, word_q[23:8]};
      cnt_d  = cnt_q + 61'd1;
      if (pos == POS_LAST) begin
        lw_d    = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
                    d: chain_q[3], e: chain_q[4]};
        rw_d    = lw_d;
        round_d = '0;
        phase_d = 1'b0;
        state_d = ST_ROUND;
      end
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_q[i] <= CHAIN_INIT[i];
      end
      cnt_q   <= '0;
      round_q <= '0;
      phase_q <= 1'b0;
      idx_q   <= '0;
      lcnt_q  <= '0;
      first_q <= 1'b0;
      inlen_q <= 1'b0;
      done_q  <= 1'b0;
      pad_q   <= 1'b0;
    end else begin
      chain_q <= chain_d;
      cnt_q   <= cnt_d;
      round_q <= round_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      lcnt_q  <= lcnt_d;
      first_q <= first_d;
      inlen_q <= inlen_d;
      done_q  <= done_d;
      pad_q   <= pad_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lw_q   <= lw_d;
    rw_q   <= rw_d;
    lsum_q <= lsum_d;
    rsum_q <= rsum_d;
    word_q <= word_d;
    len_q  <= len_d;
  end

endmodule

// ----- rtl/core/rmd160_checker.sv -----
// Port-level checker for the RIPEMD-160 core, bound to the top level
`include "ripemd160_hash_core_macros.svh"

module rmd160_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input rmd160_pkg::in_t  in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input rmd160_pkg::out_t out_data_o
);
  import rmd160_pkg::*;

  // A stalled output beat holds
  `RMD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "output beat changed while stalled")

  // No input taken while the digest is being delivered
  `RMD_ASSERT_IMP(a_busy_emit, clk_i, rst_ni, out_valid_o, in_stall_o,
    "input ready while digest pending")

  // Digest words come back to back until the last one
  `RMD_ASSERT_NXT(a_word_run, clk_i, rst_ni,
    out_valid_o && !out_stall_i && !out_data_o.last_word, out_valid_o,
    "digest word sequence broken")

  // After the last word the output goes quiet
  `RMD_ASSERT_NXT(a_last_ends, clk_i, rst_ni,
    out_valid_o && !out_stall_i && out_data_o.last_word, !out_valid_o,
    "output valid after last digest word")

  // An end beat starts padding: busy, nothing emitted yet
  `RMD_ASSERT_NXT(a_end_pads, clk_i, rst_ni,
    in_valid_i && !in_stall_o && (in_data_i.kind == KIND_END),
    in_stall_o && !out_valid_o, "end beat did not start padding")

endmodule

bind ripemd160_hash_core rmd160_checker u_rmd160_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
